### hdl/rla_pkg.sv
// ----------------------------------------------------------------------------
// rla_pkg
// Shared types and constants of the receive line assembler queue: controller
// states, character codes and the command and status groups.
// ----------------------------------------------------------------------------
package rla_pkg;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [5:0] MAX_RESULTS = 6'd63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_LOOK,
    ST_FIRST,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic build_append;
    logic build_clear;
    logic copy_start;
    logic copy_step;
    logic read_start;
    logic limit_load;
    logic first_load;
    logic emit_step;
    logic emit_none;
    logic emit_blank;
    logic emit_byte;
  } cmd_t;

  typedef struct packed {
    logic req_read;
    logic rx_err;
    logic is_cr;
    logic is_lf;
    logic build_empty;
    logic build_full;
    logic queue_empty;
    logic queue_full;
    logic copy_last;
    logic limit_zero;
    logic data_zero;
    logic emit_end;
  } status_t;

endpackage

### hdl/rla_ram.sv
// ----------------------------------------------------------------------------
// rla_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module rla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/rla_ctrl.sv
// ----------------------------------------------------------------------------
// rla_ctrl
// Controller: sequences byte handling, line copy into the queue and line
// read-out, and drives the datapath commands.
// ----------------------------------------------------------------------------
module rla_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  rla_pkg::status_t status,
  output rla_pkg::cmd_t    cmd,
  output logic             busy
);
  import rla_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (status.req_read) begin
            if (!status.queue_empty) state_next = ST_LOOK;
          end else if (!status.rx_err && status.is_lf && !status.build_empty &&
                       !status.queue_full) begin
            state_next = ST_COPY;
          end
        end
      end
      ST_COPY: begin
        if (status.copy_last) state_next = ST_IDLE;
      end
      ST_LOOK: begin
        state_next = status.limit_zero ? ST_IDLE : ST_FIRST;
      end
      ST_FIRST: begin
        state_next = status.data_zero ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (status.emit_end) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          priority if (status.req_read) begin
            if (status.queue_empty) cmd.emit_none = 1'b1;
            else cmd.read_start = 1'b1;
          end else if (status.rx_err || status.is_cr) begin
            // dropped
          end else if (status.is_lf) begin
            priority if (status.build_empty) begin
            end else if (status.queue_full) begin
              cmd.build_clear = 1'b1;
            end else begin
              cmd.copy_start = 1'b1;
            end
          end else if (status.build_full) begin
            cmd.build_clear = 1'b1;
          end else begin
            cmd.build_append = 1'b1;
          end
        end
      end
      ST_COPY: begin
        cmd.copy_step = 1'b1;
      end
      ST_LOOK: begin
        cmd.limit_load = 1'b1;
        if (status.limit_zero) cmd.emit_blank = 1'b1;
      end
      ST_FIRST: begin
        if (status.data_zero) cmd.emit_blank = 1'b1;
        else cmd.first_load = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit_byte = 1'b1;
        if (!status.emit_end) cmd.emit_step = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

### hdl/rla_dp.sv
// ----------------------------------------------------------------------------
// rla_dp
// Datapath: build buffer, line queue storage, slot pointers, read-out
// counters and the registered result ports.
// ----------------------------------------------------------------------------
module rla_dp #(
  parameter int LINE_BYTES  = 64,
  parameter int QUEUE_LINES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  rla_pkg::cmd_t    cmd,
  output rla_pkg::status_t status,
  input  logic             req_type,
  input  logic [7:0]       rx_byte,
  input  logic             rx_error,
  input  logic [6:0]       read_max_len,
  output logic             result_valid,
  output logic             line_ready,
  output logic             char_valid,
  output logic [7:0]       char_out,
  output logic             last,
  output logic [5:0]       lines_waiting
);
  import rla_pkg::*;

  localparam int IDX_W  = $clog2(LINE_BYTES);
  localparam int SLOT_W = $clog2(QUEUE_LINES);
  localparam int CNT_W  = $clog2(QUEUE_LINES + 1);
  localparam int ADDR_W = $clog2(LINE_BYTES * QUEUE_LINES);

  logic [IDX_W-1:0]  blen;
  logic [IDX_W-1:0]  cp;
  logic [SLOT_W-1:0] wslot;
  logic [SLOT_W-1:0] rslot;
  logic [SLOT_W-1:0] rrow;
  logic [CNT_W-1:0]  count;
  logic [5:0]        mcap;
  logic [5:0]        limit;
  logic [5:0]        idx;
  logic [6:0]        rp;
  logic [7:0]        held;

  logic [7:0]        build_rd;
  logic [7:0]        line_rd;
  logic [IDX_W-1:0]  len_rd;
  logic [ADDR_W-1:0] line_waddr;
  logic [ADDR_W-1:0] line_raddr;
  logic              line_we;
  logic [6:0]        mlen_m1;
  logic [5:0]        mcap_next;
  logic [5:0]        limit_next;
  logic              emit_end;

  assign line_we    = cmd.copy_step && (cp != '0);
  assign line_waddr = ADDR_W'(ADDR_W'(wslot) * ADDR_W'(LINE_BYTES) + ADDR_W'(cp - IDX_W'(1)));
  assign line_raddr = ADDR_W'(ADDR_W'(rrow) * ADDR_W'(LINE_BYTES) + ADDR_W'(rp));

  rla_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_build (
    .clk  (clk),
    .we   (cmd.build_append),
    .waddr(blen),
    .wdata(rx_byte),
    .raddr(cp),
    .rdata(build_rd)
  );

  rla_ram #(.WIDTH(8), .DEPTH(LINE_BYTES * QUEUE_LINES)) u_lines (
    .clk  (clk),
    .we   (line_we),
    .waddr(line_waddr),
    .wdata(build_rd),
    .raddr(line_raddr),
    .rdata(line_rd)
  );

  rla_ram #(.WIDTH(IDX_W), .DEPTH(QUEUE_LINES)) u_lens (
    .clk  (clk),
    .we   (cmd.copy_start),
    .waddr(wslot),
    .wdata(blen),
    .raddr(rslot),
    .rdata(len_rd)
  );

  assign mlen_m1    = (read_max_len == 7'd0) ? 7'd0 : read_max_len - 7'd1;
  assign mcap_next  = (mlen_m1 > 7'(MAX_RESULTS)) ? MAX_RESULTS : 6'(mlen_m1);
  assign limit_next = (9'(len_rd) < 9'(mcap)) ? 6'(len_rd) : mcap;
  assign emit_end   = ((7'(idx) + 7'd1) == 7'(limit)) || (line_rd == 8'd0);

  always_comb begin
    status.req_read    = req_type;
    status.rx_err      = rx_error;
    status.is_cr       = (rx_byte == CH_CR);
    status.is_lf       = (rx_byte == CH_LF);
    status.build_empty = (blen == '0);
    status.build_full  = (blen == IDX_W'(LINE_BYTES - 1));
    status.queue_empty = (count == '0);
    status.queue_full  = (count == CNT_W'(QUEUE_LINES));
    status.copy_last   = (cp == blen);
    status.limit_zero  = (limit_next == 6'd0);
    status.data_zero   = (line_rd == 8'd0);
    status.emit_end    = emit_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blen  <= '0;
      wslot <= '0;
      rslot <= '0;
      count <= '0;
    end else begin
      if (cmd.build_append) blen <= blen + IDX_W'(1);
      if (cmd.build_clear) blen <= '0;
      if (cmd.copy_step && status.copy_last) begin
        blen  <= '0;
        wslot <= (wslot == SLOT_W'(QUEUE_LINES - 1)) ? '0 : wslot + SLOT_W'(1);
        count <= count + CNT_W'(1);
      end
      if (cmd.read_start) begin
        rslot <= (rslot == SLOT_W'(QUEUE_LINES - 1)) ? '0 : rslot + SLOT_W'(1);
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_start) cp <= '0;
    else if (cmd.copy_step) cp <= cp + IDX_W'(1);
    if (cmd.read_start) begin
      rrow <= rslot;
      mcap <= mcap_next;
      rp   <= 7'd0;
    end
    if (cmd.limit_load) begin
      limit <= limit_next;
      rp    <= 7'd1;
    end
    if (cmd.first_load) begin
      held <= line_rd;
      idx  <= 6'd0;
      rp   <= 7'd2;
    end
    if (cmd.emit_step) begin
      held <= line_rd;
      idx  <= idx + 6'd1;
      rp   <= rp + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_none || cmd.emit_blank || cmd.emit_byte;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.emit_none) begin
      line_ready    <= 1'b0;
      char_valid    <= 1'b0;
      char_out      <= 8'd0;
      last          <= 1'b1;
      lines_waiting <= 6'd0;
    end else if (cmd.emit_blank) begin
      line_ready    <= 1'b1;
      char_valid    <= 1'b0;
      char_out      <= 8'd0;
      last          <= 1'b1;
      lines_waiting <= 6'(count);
    end else if (cmd.emit_byte) begin
      line_ready    <= 1'b1;
      char_valid    <= 1'b1;
      char_out      <= held;
      last          <= emit_end;
      lines_waiting <= 6'(count);
    end else begin
    end
  end

endmodule

### hdl/rx_line_assembler_queue.sv
// ----------------------------------------------------------------------------
// rx_line_assembler_queue
// Line-buffered receive queue: assembles received bytes into lines, queues
// them and plays the oldest line back one byte per result on request.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A received byte leaves
// busy low. A line feed that queues a line keeps busy high while the line is
// copied from the build buffer into the queue memory, one byte a cycle through
// its single write port. A read on an empty queue leaves busy low and its
// result follows in the next cycle. A read of a queued line keeps busy high
// through the length lookup, the first byte fetch, then one result per cycle
// from the queue memory read port. A read of a queued line that yields no
// bytes gives a single result and ends after the length lookup when
// read_max_len leaves no room, or after the first byte fetch when the line
// starts with a zero byte. Each result is shown for exactly one cycle with
// result_valid high and the receiver cannot hold it off.
module rx_line_assembler_queue #(
  parameter int LINE_BYTES  = 64,
  parameter int QUEUE_LINES = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       req_type,
  input  logic [7:0] rx_byte,
  input  logic       rx_error,
  input  logic [6:0] read_max_len,
  output logic       result_valid,
  output logic       line_ready,
  output logic       char_valid,
  output logic [7:0] char_out,
  output logic       last,
  output logic [5:0] lines_waiting
);
  import rla_pkg::*;

  cmd_t    cmd;
  status_t status;

  rla_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  rla_dp #(
    .LINE_BYTES (LINE_BYTES),
    .QUEUE_LINES(QUEUE_LINES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .req_type     (req_type),
    .rx_byte      (rx_byte),
    .rx_error     (rx_error),
    .read_max_len (read_max_len),
    .result_valid (result_valid),
    .line_ready   (line_ready),
    .char_valid   (char_valid),
    .char_out     (char_out),
    .last         (last),
    .lines_waiting(lines_waiting)
  );

endmodule

### hdl/rla_checker.sv
// ----------------------------------------------------------------------------
// rla_checker
// Port-level checks of the receive line assembler queue, bound to the top
// level.
// ----------------------------------------------------------------------------
module rla_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       req_type,
  input logic       result_valid,
  input logic       line_ready,
  input logic       char_valid,
  input logic [7:0] char_out,
  input logic       last,
  input logic [5:0] lines_waiting
);

  // idle after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy after reset");

  // empty queue result shape
  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && !line_ready |->
      last && !char_valid && (char_out == 8'd0) && (lines_waiting == 6'd0))
    else $error("bad empty queue result");

  // a result without a byte ends the read
  a_blank_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !char_valid |-> last)
    else $error("result without byte not last");

  // bytes of one line come back to back
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> result_valid && line_ready && char_valid)
    else $error("gap inside a line read");

  // a received byte gives no result
  a_byte_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !req_type |=> !result_valid)
    else $error("result after a received byte");

endmodule

bind rx_line_assembler_queue rla_checker u_rla_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .req_type     (req_type),
  .result_valid (result_valid),
  .line_ready   (line_ready),
  .char_valid   (char_valid),
  .char_out     (char_out),
  .last         (last),
  .lines_waiting(lines_waiting)
);
